// ===== hw/rtl/khab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khab_pkg
// Shared constants and types for the key hash access bitmap unit.
// ----------------------------------------------------------------------------
package khab_pkg;

    // default geometry
    localparam int unsigned MAP_BYTES_DEFAULT    = 4096;
    localparam int unsigned HASH_MODULUS_DEFAULT = 16381;

    // hash and cell constants
    localparam logic [31:0] HASH_MULT_RESET = 32'd131;
    localparam logic [31:0] HASH_MASK31     = 32'h7FFF_FFFF;
    localparam logic [1:0]  RD_ACCESS_BIT   = 2'b01;
    localparam logic [1:0]  WR_ACCESS_BIT   = 2'b10;
    localparam logic [1:0]  CELL_MASK       = 2'b11;

    // input word modes
    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // result kinds
    localparam logic [1:0] RK_UPDATE = 2'd0;
    localparam logic [1:0] RK_READ   = 2'd1;
    localparam logic [1:0] RK_CLEAR  = 2'd2;

    // register index (paddr[2])
    localparam logic REG_HASH_MULT = 1'b0;

    // result queue depth
    localparam int unsigned OUT_DEPTH = 8;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  map_byte;
        logic [1:0]  new_cell;
        logic [1:0]  old_cell;
        logic [13:0] cell_index;
    } result_t;

endpackage

// ===== hw/rtl/key_hash_access_bitmap_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_hash_access_bitmap_unit
// Streaming BKDR key hash that marks read/write accesses in a 2-bit cell map.
// ----------------------------------------------------------------------------
// Key bytes, map byte reads and key-final updates are taken one word per
// cycle while s_tready is high; a result word is presented after its input
// word passes a two-stage reciprocal reduction modulo HASH_MODULUS, a final
// correction with the map RAM read, then the modify and write-back with
// forwarding from the previous write. Results queue in an eight-entry output
// buffer, so the input keeps flowing while m_tready is low until queued and
// in-flight results fill that buffer. A clear-map word drains the pipeline and
// then sweeps the map RAM one byte per cycle, all MAP_BYTES (4096 by default),
// before reporting clear done; the same sweep runs after reset, and s_tready
// is low during it. hash_multiplier resets to 131; the user must write it
// at APB byte address 0 only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module key_hash_access_bitmap_unit #(
    parameter int unsigned MAP_BYTES    = khab_pkg::MAP_BYTES_DEFAULT,
    parameter int unsigned HASH_MODULUS = khab_pkg::HASH_MODULUS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_byte[7:0], access_kind[8], byte_address[20:9]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    input  logic        s_tlast,   // last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cell_index[13:0], old_cell[15:14], new_cell[17:16],
                                   // map_byte[25:18]
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import khab_pkg::*;

    localparam int unsigned AW         = $clog2(MAP_BYTES);
    localparam int unsigned CELL_COUNT = 4 * MAP_BYTES;
    localparam logic [31:0] RECIP      = 32'((64'd1 << 32) / HASH_MODULUS);
    localparam logic [15:0] MOD16      = 16'(HASH_MODULUS);
    localparam int unsigned PW         = $clog2(OUT_DEPTH);
    localparam int unsigned CW         = $clog2(OUT_DEPTH + 1);

    // subtract the limit up to three times (values below four limits)
    function automatic logic [31:0] wrap3(input logic [31:0] v, input logic [31:0] lim);
        logic [31:0] t;
        t = v;
        for (int i = 0; i < 3; i++) begin
            if (t >= lim) begin
                t = t - lim;
            end
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [31:0] mult_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HASH_MULT);
    assign prdata = (paddr[2] == REG_HASH_MULT) ? mult_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg <= HASH_MULT_RESET;
        end else if (cfg_wr) begin
            mult_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // input word and running hash
    // ------------------------------------------------------------------
    logic        s_accept;
    logic [1:0]  in_mode;
    logic [7:0]  in_key;
    logic        in_kind;
    logic [11:0] in_addr;
    logic        in_enter;
    logic [31:0] hash_reg;
    logic [63:0] hash_prod;
    logic [31:0] hash_next;
    logic [31:0] hash_masked;

    assign in_mode  = s_tuser;
    assign in_key   = s_tdata[7:0];
    assign in_kind  = s_tdata[8];
    assign in_addr  = s_tdata[20:9];
    assign s_accept = s_tvalid && s_tready;

    assign hash_prod   = {32'd0, hash_reg} * {32'd0, mult_reg};
    assign hash_next   = hash_prod[31:0] + {{24{in_key[7]}}, in_key};
    assign hash_masked = hash_next & HASH_MASK31;

    // words that produce a result enter the pipeline
    assign in_enter = s_accept &&
                      (((in_mode == MODE_KEY) && s_tlast) ||
                       (in_mode == MODE_CLEAR) || (in_mode == MODE_READ));

    // advance the hash, restart after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= 32'd0;
        end else if (s_accept && (in_mode == MODE_KEY)) begin
            hash_reg <= s_tlast ? 32'd0 : hash_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    logic        st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg;
    logic [1:0]  st1_mode_reg, st2_mode_reg, st3_mode_reg, st4_mode_reg;
    logic        st1_kind_reg, st2_kind_reg, st3_kind_reg, st4_kind_reg;
    logic [11:0] st1_addr_reg, st2_addr_reg, st3_addr_reg;
    logic [30:0] st1_h_reg;
    logic [15:0] st2_h_reg, st2_q_reg, st3_r_reg;
    logic [13:0] st4_idx_reg;
    logic [1:0]  st4_sel_reg;
    logic [AW-1:0] st4_baddr_reg;

    // stage 1: quotient estimate by reciprocal
    logic [62:0] recip_prod;
    assign recip_prod = {32'd0, st1_h_reg} * {31'd0, RECIP};

    // stage 2: remainder estimate, below twice the modulus
    logic [31:0] mod_prod;
    logic [15:0] rem_est;
    assign mod_prod = {16'd0, st2_q_reg} * {16'd0, MOD16};
    assign rem_est  = st2_h_reg - mod_prod[15:0];

    // stage 3: final index, storage cell and RAM read address
    logic [15:0]   idx16;
    logic [13:0]   idx;
    logic [31:0]   cell32;
    logic [31:0]   addr32;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    assign idx16  = (st3_r_reg >= MOD16) ? (st3_r_reg - MOD16) : st3_r_reg;
    assign idx    = idx16[13:0];
    assign cell32 = wrap3({18'd0, idx}, 32'(CELL_COUNT));
    assign addr32 = wrap3({20'd0, st3_addr_reg}, 32'(MAP_BYTES));
    assign rd_addr = (st3_mode_reg == MODE_READ) ? addr32[AW-1:0] : cell32[AW+1:2];
    assign rd_en   = st3_valid_reg &&
                     ((st3_mode_reg == MODE_KEY) || (st3_mode_reg == MODE_READ));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= in_enter;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        st1_mode_reg  <= in_mode;
        st1_kind_reg  <= in_kind;
        st1_addr_reg  <= in_addr;
        st1_h_reg     <= hash_masked[30:0];

        st2_mode_reg  <= st1_mode_reg;
        st2_kind_reg  <= st1_kind_reg;
        st2_addr_reg  <= st1_addr_reg;
        st2_h_reg     <= st1_h_reg[15:0];
        st2_q_reg     <= recip_prod[47:32];

        st3_mode_reg  <= st2_mode_reg;
        st3_kind_reg  <= st2_kind_reg;
        st3_addr_reg  <= st2_addr_reg;
        st3_r_reg     <= rem_est;

        st4_mode_reg  <= st3_mode_reg;
        st4_kind_reg  <= st3_kind_reg;
        st4_idx_reg   <= idx;
        st4_sel_reg   <= cell32[1:0];
        st4_baddr_reg <= rd_addr;
    end

    // ------------------------------------------------------------------
    // map RAM, forwarding and clear sweep
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;

    logic          sweep_busy_reg;
    logic          sweep_report_reg;
    logic [AW-1:0] sweep_cnt_reg;
    logic          sweep_last;
    logic          clr_hold_reg;

    logic [7:0]    cur_byte;
    logic [2:0]    shamt;
    logic [7:0]    shifted;
    logic [1:0]    old_cell;
    logic [1:0]    new_cell;
    logic [7:0]    new_byte;
    logic          st4_update;
    logic          st4_read;
    logic          st4_clear;

    assign st4_update = st4_valid_reg && (st4_mode_reg == MODE_KEY);
    assign st4_read   = st4_valid_reg && (st4_mode_reg == MODE_READ);
    assign st4_clear  = st4_valid_reg && (st4_mode_reg == MODE_CLEAR);

    // take the byte written last cycle if the RAM read missed it
    assign cur_byte = (fwd_valid_reg && (fwd_addr_reg == st4_baddr_reg)) ?
                      fwd_data_reg : ram_rdata;
    assign shamt    = {st4_sel_reg, 1'b0};
    assign shifted  = cur_byte >> shamt;
    assign old_cell = shifted[1:0] & CELL_MASK;
    assign new_cell = old_cell | (st4_kind_reg ? WR_ACCESS_BIT : RD_ACCESS_BIT);
    assign new_byte = (cur_byte & ~({6'd0, CELL_MASK} << shamt)) |
                      ({6'd0, new_cell} << shamt);

    assign sweep_last = (sweep_cnt_reg == AW'(MAP_BYTES - 1));
    assign ram_we     = sweep_busy_reg || st4_update;
    assign ram_waddr  = sweep_busy_reg ? sweep_cnt_reg : st4_baddr_reg;
    assign ram_wdata  = sweep_busy_reg ? 8'd0 : new_byte;

    khab_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // register the last update for forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= st4_update && !sweep_busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= st4_baddr_reg;
        fwd_data_reg <= new_byte;
    end

    // sweep the map after reset and on a clear word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_busy_reg   <= 1'b1;
            sweep_report_reg <= 1'b0;
            sweep_cnt_reg    <= '0;
            clr_hold_reg     <= 1'b0;
        end else begin
            if (s_accept && (in_mode == MODE_CLEAR)) begin
                clr_hold_reg <= 1'b1;
            end
            if (sweep_busy_reg) begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_last) begin
                    sweep_busy_reg   <= 1'b0;
                    sweep_report_reg <= 1'b0;
                    clr_hold_reg     <= 1'b0;
                end
            end else if (st4_clear) begin
                sweep_busy_reg   <= 1'b1;
                sweep_report_reg <= 1'b1;
                sweep_cnt_reg    <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    result_t       out_q [OUT_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fifo_cnt_reg;
    logic          push;
    logic          pop;
    result_t       push_data;
    logic [2:0]    pend;
    logic [CW:0]   credit_sum;

    always_comb begin
        push      = 1'b0;
        push_data = '0;
        if (sweep_busy_reg && sweep_last && sweep_report_reg) begin
            push                  = 1'b1;
            push_data.result_kind = RK_CLEAR;
        end else if (st4_update) begin
            push                  = 1'b1;
            push_data.result_kind = RK_UPDATE;
            push_data.cell_index  = st4_idx_reg;
            push_data.old_cell    = old_cell;
            push_data.new_cell    = new_cell;
            push_data.map_byte    = new_byte;
        end else if (st4_read) begin
            push                  = 1'b1;
            push_data.result_kind = RK_READ;
            push_data.map_byte    = cur_byte;
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tuser  = out_q[rd_ptr_reg].result_kind;
    assign m_tdata  = {6'd0, out_q[rd_ptr_reg].map_byte, out_q[rd_ptr_reg].new_cell,
                       out_q[rd_ptr_reg].old_cell, out_q[rd_ptr_reg].cell_index};

    // accept only while every word in flight has a queue slot
    assign pend       = {2'd0, st1_valid_reg} + {2'd0, st2_valid_reg} +
                        {2'd0, st3_valid_reg} + {2'd0, st4_valid_reg};
    assign credit_sum = {1'b0, fifo_cnt_reg} + (CW + 1)'(pend);
    assign s_tready   = !sweep_busy_reg && !clr_hold_reg &&
                        (credit_sum < (CW + 1)'(OUT_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
            end else if (pop && !push) begin
                fifo_cnt_reg <= fifo_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_q[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/khab_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khab_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module khab_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
